>>> design/msie_pkg.sv
// msie_pkg: shared types, function codes and controller commands for the
// SPECIAL-class execute block. No dependencies.
`default_nettype none
package msie_pkg;

    localparam int unsigned DataWidth = 64;
    localparam int unsigned CountWidth = 7;

    localparam logic [5:0] FnSll    = 6'h00;
    localparam logic [5:0] FnSrl    = 6'h02;
    localparam logic [5:0] FnSra    = 6'h03;
    localparam logic [5:0] FnSllv   = 6'h04;
    localparam logic [5:0] FnSrlv   = 6'h06;
    localparam logic [5:0] FnSrav   = 6'h07;
    localparam logic [5:0] FnJr     = 6'h08;
    localparam logic [5:0] FnJalr   = 6'h09;
    localparam logic [5:0] FnSync   = 6'h0F;
    localparam logic [5:0] FnMfhi   = 6'h10;
    localparam logic [5:0] FnMthi   = 6'h11;
    localparam logic [5:0] FnMflo   = 6'h12;
    localparam logic [5:0] FnMtlo   = 6'h13;
    localparam logic [5:0] FnDsllv  = 6'h14;
    localparam logic [5:0] FnDsrlv  = 6'h16;
    localparam logic [5:0] FnDsrav  = 6'h17;
    localparam logic [5:0] FnMult   = 6'h18;
    localparam logic [5:0] FnMultu  = 6'h19;
    localparam logic [5:0] FnDiv    = 6'h1A;
    localparam logic [5:0] FnDivu   = 6'h1B;
    localparam logic [5:0] FnDmult  = 6'h1C;
    localparam logic [5:0] FnDmultu = 6'h1D;
    localparam logic [5:0] FnDdiv   = 6'h1E;
    localparam logic [5:0] FnDdivu  = 6'h1F;
    localparam logic [5:0] FnAdd    = 6'h20;
    localparam logic [5:0] FnAddu   = 6'h21;
    localparam logic [5:0] FnSub    = 6'h22;
    localparam logic [5:0] FnSubu   = 6'h23;
    localparam logic [5:0] FnAnd    = 6'h24;
    localparam logic [5:0] FnOr     = 6'h25;
    localparam logic [5:0] FnXor    = 6'h26;
    localparam logic [5:0] FnNor    = 6'h27;
    localparam logic [5:0] FnSlt    = 6'h2A;
    localparam logic [5:0] FnSltu   = 6'h2B;
    localparam logic [5:0] FnDadd   = 6'h2C;
    localparam logic [5:0] FnDaddu  = 6'h2D;
    localparam logic [5:0] FnDsub   = 6'h2E;
    localparam logic [5:0] FnDsubu  = 6'h2F;
    localparam logic [5:0] FnDsll   = 6'h38;
    localparam logic [5:0] FnDsrl   = 6'h3A;
    localparam logic [5:0] FnDsra   = 6'h3B;
    localparam logic [5:0] FnDsll32 = 6'h3C;
    localparam logic [5:0] FnDsrl32 = 6'h3E;
    localparam logic [5:0] FnDsra32 = 6'h3F;

    typedef struct packed {
        logic [5:0]  funct;
        logic [4:0]  shift_amount;
        logic [4:0]  dest_reg;
        logic [63:0] rs_value;
        logic [63:0] rt_value;
        logic [31:0] pc;
    } in_word_t;

    typedef struct packed {
        logic        write_enable;
        logic [4:0]  dest_index;
        logic [63:0] write_value;
        logic        jump_taken;
        logic [63:0] jump_target;
        logic        undefined;
    } out_word_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_DIV,
        ST_FIX,
        ST_OUT
    } state_t;

    typedef enum logic [1:0] {
        OP_SIMPLE,
        OP_MUL,
        OP_DIV
    } op_class_t;

    // controller -> datapath
    typedef struct packed {
        logic load;     // capture input word, run single-cycle ops
        logic mul_step; // one shift-add multiply step
        logic div_step; // one restoring divide step
        logic finish;   // sign fix and HI/LO commit
    } cmd_t;

    // datapath -> controller
    typedef struct packed {
        op_class_t op_class;
        logic      last;  // iteration counter at final step
    } status_t;

    function automatic logic [63:0] sext32(input logic [31:0] w);
        return {{32{w[31]}}, w};
    endfunction

endpackage
`default_nettype wire

>>> design/msie_ctrl.sv
// msie_ctrl: sequencing state machine for the execute block.
// Depends on msie_pkg.
`default_nettype none
module msie_ctrl (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              s_valid,
    output logic                   s_ready,
    output logic                   m_valid,
    input  wire logic              m_ready,
    input  wire msie_pkg::status_t stat,
    output msie_pkg::cmd_t         cmd
);
    msie_pkg::state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= msie_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            msie_pkg::ST_IDLE: if (s_valid) state_next = msie_pkg::ST_FIX;
            msie_pkg::ST_FIX: begin
                // after load: pick path by op class
                unique case (stat.op_class)
                    msie_pkg::OP_MUL: state_next = msie_pkg::ST_MUL;
                    msie_pkg::OP_DIV: state_next = msie_pkg::ST_DIV;
                    default:          state_next = msie_pkg::ST_OUT;
                endcase
            end
            msie_pkg::ST_MUL: if (stat.last) state_next = msie_pkg::ST_OUT;
            msie_pkg::ST_DIV: if (stat.last) state_next = msie_pkg::ST_OUT;
            msie_pkg::ST_OUT: begin
                if (m_ready) state_next = msie_pkg::ST_IDLE;
            end
            default: state_next = msie_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        cmd = '0;
        s_ready = 1'b0;
        m_valid = 1'b0;
        unique case (state_reg)
            msie_pkg::ST_IDLE: begin
                s_ready  = 1'b1;
                cmd.load = s_valid;
            end
            msie_pkg::ST_MUL: begin
                cmd.mul_step = 1'b1;
                cmd.finish   = stat.last;
            end
            msie_pkg::ST_DIV: begin
                cmd.div_step = 1'b1;
                cmd.finish   = stat.last;
            end
            msie_pkg::ST_OUT: m_valid = 1'b1;
            default: ;
        endcase
    end
endmodule
`default_nettype wire

>>> design/msie_dp.sv
// msie_dp: operand registers, ALU/shifter, shift-add multiplier,
// restoring divider and HI/LO. Depends on msie_pkg.
`default_nettype none
module msie_dp (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire msie_pkg::in_word_t s_word,
    input  wire msie_pkg::cmd_t     cmd,
    output msie_pkg::status_t       stat,
    output msie_pkg::out_word_t     m_word
);
    localparam int unsigned W = msie_pkg::DataWidth;

    logic [63:0] hi_reg, lo_reg, hi_next, lo_next;
    msie_pkg::out_word_t res_reg, res_next;
    msie_pkg::op_class_t cls_reg, cls_next;
    logic [63:0] a_reg, b_reg;          // magnitudes for divide; a also holds the multiplicand
    logic [63:0] acc_reg;               // mul high accumulator or div remainder
    logic [63:0] q_reg;                 // mul low product / div quotient
    logic [msie_pkg::CountWidth-1:0] cnt_reg;
    logic neg_q_reg, neg_r_reg, skip_reg, wide_reg;

    // single-cycle result
    logic [63:0] rs, rt, val;
    logic [31:0] rs32, rt32;
    logic [4:0]  sa;
    logic        we, jmp, und;
    logic [64:0] add65, sub65;

    always_comb begin
        rs = s_word.rs_value;
        rt = s_word.rt_value;
        rs32 = rs[31:0];
        rt32 = rt[31:0];
        sa = s_word.shift_amount;
        add65 = {1'b0, rs} + {1'b0, rt};
        sub65 = {1'b0, rs} - {1'b0, rt};
        we = 1'b1; jmp = 1'b0; und = 1'b0; val = '0;
        cls_next = msie_pkg::OP_SIMPLE;
        unique case (s_word.funct)
            msie_pkg::FnSll:  val = msie_pkg::sext32(rt32 << sa);
            msie_pkg::FnSrl:  val = msie_pkg::sext32(rt32 >> sa);
            msie_pkg::FnSra:  val = msie_pkg::sext32(32'($signed(rt32) >>> sa));
            msie_pkg::FnSllv: val = msie_pkg::sext32(rt32 << rs[4:0]);
            msie_pkg::FnSrlv: val = msie_pkg::sext32(rt32 >> rs[4:0]);
            msie_pkg::FnSrav: val = msie_pkg::sext32(32'($signed(rt32) >>> rs[4:0]));
            msie_pkg::FnJr:   begin we = 1'b0; jmp = 1'b1; end
            msie_pkg::FnJalr: begin
                jmp = 1'b1;
                val = {32'b0, s_word.pc + 32'd8};
            end
            msie_pkg::FnSync: we = 1'b0;
            msie_pkg::FnMfhi: val = hi_reg;
            msie_pkg::FnMflo: val = lo_reg;
            msie_pkg::FnMthi, msie_pkg::FnMtlo: we = 1'b0;
            msie_pkg::FnDsllv: val = rt << rs[5:0];
            msie_pkg::FnDsrlv: val = rt >> rs[5:0];
            msie_pkg::FnDsrav: val = 64'($signed(rt) >>> rs[5:0]);
            msie_pkg::FnMult, msie_pkg::FnMultu, msie_pkg::FnDmult,
            msie_pkg::FnDmultu: begin
                we = 1'b0; cls_next = msie_pkg::OP_MUL;
            end
            msie_pkg::FnDiv, msie_pkg::FnDivu, msie_pkg::FnDdiv,
            msie_pkg::FnDdivu: begin
                we = 1'b0; cls_next = msie_pkg::OP_DIV;
            end
            msie_pkg::FnAdd, msie_pkg::FnAddu: val = msie_pkg::sext32(add65[31:0]);
            msie_pkg::FnSub, msie_pkg::FnSubu: val = msie_pkg::sext32(sub65[31:0]);
            msie_pkg::FnAnd: val = rs & rt;
            msie_pkg::FnOr:  val = rs | rt;
            msie_pkg::FnXor: val = rs ^ rt;
            msie_pkg::FnNor: val = ~(rs | rt);
            msie_pkg::FnSlt: val = {63'b0, $signed(rs) < $signed(rt)};
            msie_pkg::FnSltu: val = {63'b0, sub65[64]};
            msie_pkg::FnDadd, msie_pkg::FnDaddu: val = add65[63:0];
            msie_pkg::FnDsub, msie_pkg::FnDsubu: val = sub65[63:0];
            msie_pkg::FnDsll:   val = rt << sa;
            msie_pkg::FnDsrl:   val = rt >> sa;
            msie_pkg::FnDsra:   val = 64'($signed(rt) >>> sa);
            msie_pkg::FnDsll32: val = rt << {1'b1, sa};
            msie_pkg::FnDsrl32: val = rt >> {1'b1, sa};
            msie_pkg::FnDsra32: val = 64'($signed(rt) >>> {1'b1, sa});
            default: begin we = 1'b0; und = 1'b1; end
        endcase
        res_next.write_enable = we;
        res_next.dest_index   = we ? s_word.dest_reg : 5'd0;
        res_next.write_value  = we ? val : 64'd0;
        res_next.jump_taken   = jmp;
        res_next.jump_target  = jmp ? rs : 64'd0;
        res_next.undefined    = und;
    end

    // operand preparation for mul/div
    logic        f_wide, f_signed, na, nb;
    logic [63:0] oa, ob, ma, mb;
    always_comb begin
        f_wide   = s_word.funct[2];            // D* forms
        f_signed = !s_word.funct[0];
        oa = f_wide ? rs : (f_signed ? msie_pkg::sext32(rs32) : {32'b0, rs32});
        ob = f_wide ? rt : (f_signed ? msie_pkg::sext32(rt32) : {32'b0, rt32});
        na = f_signed && oa[63];
        nb = f_signed && ob[63];
        ma = na ? 64'(-oa) : oa;
        mb = nb ? 64'(-ob) : ob;
    end

    // multiply and divide steps: one bit of the multiplier in q, or one quotient bit, per cycle
    logic [64:0] mul_sum;
    logic [63:0] rem_sh;
    logic [64:0] div_try;
    always_comb begin
        mul_sum = {1'b0, acc_reg} + ((q_reg[0]) ? {1'b0, a_reg} : 65'd0);
        rem_sh  = {acc_reg[62:0], q_reg[63]};
        div_try = {acc_reg[63], rem_sh} - {1'b0, b_reg};
    end

    // MTHI/MTLO writes, final sign fix / commit
    logic [127:0] prod;
    logic [63:0]  qf, rf;
    always_comb begin
        hi_next = hi_reg;
        lo_next = lo_reg;
        prod = '0; qf = '0; rf = '0;
        if (cmd.load && s_word.funct == msie_pkg::FnMthi) hi_next = rs;
        if (cmd.load && s_word.funct == msie_pkg::FnMtlo) lo_next = rs;
        if (cmd.finish) begin
            if (cls_reg == msie_pkg::OP_MUL) begin
                prod = {mul_sum, q_reg[63:1]};
                if (neg_q_reg) prod = 128'(-prod);
                if (wide_reg) begin
                    hi_next = prod[127:64]; lo_next = prod[63:0];
                end else begin
                    hi_next = msie_pkg::sext32(prod[63:32]);
                    lo_next = msie_pkg::sext32(prod[31:0]);
                end
            end else if (!skip_reg) begin
                qf = {q_reg[62:0], ~div_try[64]};
                rf = div_try[64] ? rem_sh : div_try[63:0];
                if (neg_q_reg) qf = 64'(-qf);
                if (neg_r_reg) rf = 64'(-rf);
                if (wide_reg) begin
                    hi_next = rf; lo_next = qf;
                end else begin
                    hi_next = msie_pkg::sext32(rf[31:0]);
                    lo_next = msie_pkg::sext32(qf[31:0]);
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hi_reg <= '0;
            lo_reg <= '0;
        end else begin
            hi_reg <= hi_next;
            lo_reg <= lo_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            res_reg   <= res_next;
            cls_reg   <= cls_next;
            wide_reg  <= f_wide;
            skip_reg  <= (ob == 64'd0);
            acc_reg   <= '0;
            cnt_reg   <= '0;
            neg_r_reg <= na;
            if (cls_next == msie_pkg::OP_MUL) begin
                // multiplicand in a, multiplier shifts through q
                a_reg     <= ma;
                q_reg     <= mb;
                neg_q_reg <= na ^ nb;
            end else begin
                a_reg     <= ma;
                b_reg     <= mb;
                q_reg     <= ma;
                neg_q_reg <= na ^ nb;
            end
        end else if (cmd.mul_step) begin
            acc_reg <= mul_sum[64:1];
            q_reg   <= {mul_sum[0], q_reg[63:1]};
            cnt_reg <= cnt_reg + 1'b1;
        end else if (cmd.div_step) begin
            acc_reg <= div_try[64] ? rem_sh : div_try[63:0];
            q_reg   <= {q_reg[62:0], ~div_try[64]};
            cnt_reg <= cnt_reg + 1'b1;
        end
    end

    always_comb begin
        stat.op_class = cls_reg;
        stat.last     = (cnt_reg == msie_pkg::CountWidth'(W - 1));
        m_word        = res_reg;
    end
endmodule
`default_nettype wire

>>> design/mips64_special_integer_execute.sv
// mips64_special_integer_execute: top level, joins controller and datapath.
// Depends on msie_pkg, msie_ctrl, msie_dp.
`default_nettype none
// Executes one MIPS III SPECIAL-class instruction per input word and keeps
// the HI and LO registers.
// Input channel s_*: valid/ready, payload s_word (funct, shift amount,
// destination, rs and rt values, PC). Result channel m_*: one word per
// input, carrying register write, jump and undefined-code flags.
// Single-cycle operations (ALU, shifts, moves, jumps) go from accept
// through the FIX state to OUT, which raises m_valid. Multiplies and
// divides run a 64-step shift-add or restoring-divide loop in the
// datapath, one bit a cycle, between FIX and OUT; 32-bit forms use the
// same 64 steps on extended operands. One word is in flight at a time;
// s_ready is high only when the block is idle, so a new word is taken
// only after the previous result has been accepted on m_ready.
// Reset (aresetn low, synchronous) clears HI, LO and the controller.
// When the receiver stalls, m_word holds steady with m_valid high and no
// new word is taken.
module mips64_special_integer_execute (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                s_valid,
    output logic                     s_ready,
    input  wire msie_pkg::in_word_t  s_word,
    output logic                     m_valid,
    input  wire logic                m_ready,
    output msie_pkg::out_word_t      m_word
);
    msie_pkg::cmd_t    cmd;
    msie_pkg::status_t stat;

    msie_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    msie_dp u_dp (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_word  (s_word),
        .cmd     (cmd),
        .stat    (stat),
        .m_word  (m_word)
    );
endmodule
`default_nettype wire

>>> sim/tb.sv
// tb: self-checking testbench for mips64_special_integer_execute.
// Depends on msie_pkg and the RTL under design/; predicts each result word
// from its own HI/LO model and compares every field in order.
`default_nettype none
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned ClkHalf = 6;
    localparam int unsigned CycleLimit = 3000000;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_valid = 1'b0;
    logic s_ready;
    msie_pkg::in_word_t s_word = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    msie_pkg::out_word_t m_word;

    mips64_special_integer_execute dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_word(s_word),
        .m_valid(m_valid), .m_ready(m_ready), .m_word(m_word)
    );

    initial begin
        forever #(ClkHalf) aclk = ~aclk;
    end

    // words waiting to be offered, and results predicted at acceptance
    msie_pkg::in_word_t  pending_words[$];
    msie_pkg::out_word_t expected_results[$];
    logic [63:0] model_hi = '0;
    logic [63:0] model_lo = '0;
    int unsigned mismatches = 0;
    int unsigned cycle_count = 0;
    bit stim_done = 1'b0;
    bit sender_hold = 1'b0;   // pause sender while set
    bit long_stall = 1'b0;    // receiver holds off for a long stretch

    // Predicts one result word and updates the HI/LO model.
    function automatic msie_pkg::out_word_t execute_word(input msie_pkg::in_word_t w);
        msie_pkg::out_word_t r;
        logic [63:0] rs, rt, v, q, rm, ua, ub;
        logic [31:0] rs32, rt32, q32, r32, ua32, ub32;
        logic [127:0] prod;
        logic na, nb, we, undef;
        r = '0;
        rs = w.rs_value; rt = w.rt_value;
        rs32 = rs[31:0]; rt32 = rt[31:0];
        we = 1'b1; undef = 1'b0; v = '0;
        case (w.funct)
            msie_pkg::FnSll:  v = msie_pkg::sext32(rt32 << w.shift_amount);
            msie_pkg::FnSrl:  v = msie_pkg::sext32(rt32 >> w.shift_amount);
            msie_pkg::FnSra:  v = msie_pkg::sext32($signed(rt32) >>> w.shift_amount);
            msie_pkg::FnSllv: v = msie_pkg::sext32(rt32 << rs[4:0]);
            msie_pkg::FnSrlv: v = msie_pkg::sext32(rt32 >> rs[4:0]);
            msie_pkg::FnSrav: v = msie_pkg::sext32($signed(rt32) >>> rs[4:0]);
            msie_pkg::FnJr: begin
                we = 1'b0; r.jump_taken = 1'b1; r.jump_target = rs;
            end
            msie_pkg::FnJalr: begin
                r.jump_taken = 1'b1; r.jump_target = rs;
                v = {32'h0, w.pc + 32'd8};
            end
            msie_pkg::FnSync: we = 1'b0;
            msie_pkg::FnMfhi: v = model_hi;
            msie_pkg::FnMthi: begin we = 1'b0; model_hi = rs; end
            msie_pkg::FnMflo: v = model_lo;
            msie_pkg::FnMtlo: begin we = 1'b0; model_lo = rs; end
            msie_pkg::FnDsllv: v = rt << rs[5:0];
            msie_pkg::FnDsrlv: v = rt >> rs[5:0];
            msie_pkg::FnDsrav: v = $signed(rt) >>> rs[5:0];
            msie_pkg::FnMult, msie_pkg::FnMultu: begin
                we = 1'b0;
                if (w.funct == msie_pkg::FnMult)
                    prod[63:0] = msie_pkg::sext32(rs32) * msie_pkg::sext32(rt32);
                else
                    prod[63:0] = {32'h0, rs32} * {32'h0, rt32};
                model_lo = msie_pkg::sext32(prod[31:0]);
                model_hi = msie_pkg::sext32(prod[63:32]);
            end
            msie_pkg::FnDiv, msie_pkg::FnDivu: begin
                we = 1'b0;
                if (rt32 != 0) begin
                    if (w.funct == msie_pkg::FnDivu) begin
                        q32 = rs32 / rt32; r32 = rs32 % rt32;
                    end else begin
                        na = rs32[31]; nb = rt32[31];
                        ua32 = na ? -rs32 : rs32;
                        ub32 = nb ? -rt32 : rt32;
                        q32 = ua32 / ub32; r32 = ua32 % ub32;
                        if (na != nb) q32 = -q32;
                        if (na) r32 = -r32;
                    end
                    model_lo = msie_pkg::sext32(q32);
                    model_hi = msie_pkg::sext32(r32);
                end
            end
            msie_pkg::FnDmult, msie_pkg::FnDmultu: begin
                we = 1'b0;
                if (w.funct == msie_pkg::FnDmult)
                    prod = {{64{rs[63]}}, rs} * {{64{rt[63]}}, rt};
                else
                    prod = {64'h0, rs} * {64'h0, rt};
                model_lo = prod[63:0];
                model_hi = prod[127:64];
            end
            msie_pkg::FnDdiv, msie_pkg::FnDdivu: begin
                we = 1'b0;
                if (rt != 0) begin
                    if (w.funct == msie_pkg::FnDdivu) begin
                        q = rs / rt; rm = rs % rt;
                    end else begin
                        na = rs[63]; nb = rt[63];
                        ua = na ? -rs : rs;
                        ub = nb ? -rt : rt;
                        q = ua / ub; rm = ua % ub;
                        if (na != nb) q = -q;
                        if (na) rm = -rm;
                    end
                    model_lo = q;
                    model_hi = rm;
                end
            end
            msie_pkg::FnAdd, msie_pkg::FnAddu: v = msie_pkg::sext32(rs32 + rt32);
            msie_pkg::FnSub, msie_pkg::FnSubu: v = msie_pkg::sext32(rs32 - rt32);
            msie_pkg::FnAnd: v = rs & rt;
            msie_pkg::FnOr:  v = rs | rt;
            msie_pkg::FnXor: v = rs ^ rt;
            msie_pkg::FnNor: v = ~(rs | rt);
            msie_pkg::FnSlt:  v = ($signed(rs) < $signed(rt)) ? 64'd1 : 64'd0;
            msie_pkg::FnSltu: v = (rs < rt) ? 64'd1 : 64'd0;
            msie_pkg::FnDadd, msie_pkg::FnDaddu: v = rs + rt;
            msie_pkg::FnDsub, msie_pkg::FnDsubu: v = rs - rt;
            msie_pkg::FnDsll:   v = rt << w.shift_amount;
            msie_pkg::FnDsrl:   v = rt >> w.shift_amount;
            msie_pkg::FnDsra:   v = $signed(rt) >>> w.shift_amount;
            msie_pkg::FnDsll32: v = rt << (w.shift_amount + 6'd32);
            msie_pkg::FnDsrl32: v = rt >> (w.shift_amount + 6'd32);
            msie_pkg::FnDsra32: v = $signed(rt) >>> (w.shift_amount + 6'd32);
            default: begin we = 1'b0; undef = 1'b1; end
        endcase
        r.write_enable = we;
        r.dest_index = we ? w.dest_reg : 5'd0;
        r.write_value = we ? v : 64'd0;
        r.undefined = undef;
        return r;
    endfunction

    function automatic logic [63:0] rand64();
        logic [63:0] x;
        case ($urandom_range(0, 7))
            0: x = '0;
            1: x = '1;
            2: x = 64'h8000_0000_0000_0000;
            3: x = 64'h7FFF_FFFF_FFFF_FFFF;
            4: x = {{32{1'b1}}, $urandom()};       // small negative word
            5: x = {32'h0, $urandom_range(0, 300)};
            default: x = {$urandom(), $urandom()};
        endcase
        return x;
    endfunction

    function automatic msie_pkg::in_word_t make_word(input logic [5:0] fn,
                                                     input logic [63:0] rs,
                                                     input logic [63:0] rt);
        msie_pkg::in_word_t w;
        w.funct = fn;
        w.shift_amount = 5'($urandom_range(0, 31));
        w.dest_reg = 5'($urandom_range(0, 31));
        w.rs_value = rs;
        w.rt_value = rt;
        w.pc = $urandom();
        return w;
    endfunction

    // Driver: bursts of offered words separated by random gaps.
    int unsigned burst_left = 0;
    int unsigned gap_left = 0;
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_valid && s_ready) begin
                expected_results.push_back(execute_word(s_word));
            end
            if (s_valid && !s_ready) begin
                // hold the offered word
            end else if (gap_left > 0 || sender_hold) begin
                s_valid <= 1'b0;
                if (gap_left > 0) gap_left <= gap_left - 1;
            end else if (pending_words.size() > 0) begin
                s_word <= pending_words.pop_front();
                s_valid <= 1'b1;
                if (burst_left == 0) begin
                    burst_left <= $urandom_range(1, 12);
                    gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 90);
                end else begin
                    burst_left <= burst_left - 1;
                end
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // Receiver stall pattern, plus one long hold-off on request.
    int unsigned stall_left = 0;
    int unsigned long_count = 0;
    always @(posedge aclk) begin
        if (long_stall) begin
            m_ready <= 1'b0;
            long_count <= long_count + 1;
        end else if (stall_left > 0) begin
            m_ready <= 1'b0;
            stall_left <= stall_left - 1;
        end else if ($urandom_range(0, 5) == 0) begin
            m_ready <= 1'b0;
            stall_left <= $urandom_range(0, 80);
        end else begin
            m_ready <= 1'b1;
        end
    end

    // Monitor: compare each accepted result with the oldest prediction.
    always @(posedge aclk) begin
        msie_pkg::out_word_t exp_w;
        cycle_count <= cycle_count + 1;
        if (aresetn && m_valid && m_ready) begin
            if (expected_results.size() == 0) begin
                mismatches <= mismatches + 1;
                if (mismatches < 10) $display("unexpected result word %h", m_word);
            end else begin
                exp_w = expected_results.pop_front();
                if (m_word !== exp_w) begin
                    mismatches <= mismatches + 1;
                    if (mismatches < 10)
                        $display({"mismatch: we %b/%b rd %0d/%0d val %h/%h",
                                  " jmp %b/%b tgt %h/%h und %b/%b"},
                            exp_w.write_enable, m_word.write_enable,
                            exp_w.dest_index, m_word.dest_index,
                            exp_w.write_value, m_word.write_value,
                            exp_w.jump_taken, m_word.jump_taken,
                            exp_w.jump_target, m_word.jump_target,
                            exp_w.undefined, m_word.undefined);
                end
            end
        end
        if (cycle_count >= CycleLimit) begin
            $display("** mips64_special_integer_execute: FAILED **");
            $finish;
        end
    end

    function automatic logic [5:0] pick_funct();
        logic [5:0] f;
        case ($urandom_range(0, 9))
            0: f = 6'($urandom_range(0, 63));             // anything, undefined too
            1: f = 6'($urandom_range(msie_pkg::FnMult, msie_pkg::FnDdivu));
            2: f = 6'($urandom_range(msie_pkg::FnMfhi, msie_pkg::FnMtlo));
            default: begin
                f = 6'($urandom_range(0, 63));
                // defined codes only
                while (f inside {6'd1, 6'd5, [6'd10:6'd14], 6'd21, 6'd40, 6'd41,
                                 [6'd48:6'd55], 6'd57, 6'd61})
                    f = 6'($urandom_range(0, 63));
            end
        endcase
        return f;
    endfunction

    // sampled away from the driving edge so queue and valid agree
    task automatic wait_drained();
        while (pending_words.size() > 0 || s_valid || expected_results.size() > 0)
            @(negedge aclk);
    endtask

    initial begin
        int unsigned i;
        logic [5:0] fn;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;

        // directed: reads of reset HI/LO, extremes, each special case
        pending_words.push_back(make_word(msie_pkg::FnMfhi, '0, '0));
        pending_words.push_back(make_word(msie_pkg::FnMflo, '1, '1));
        pending_words.push_back(make_word(msie_pkg::FnSync, '1, '1));
        pending_words.push_back(make_word(6'd1, '1, '1));   // undefined code
        pending_words.push_back(make_word(6'd61, '1, '1));  // undefined code
        pending_words.push_back(make_word(msie_pkg::FnDdiv,
                                          64'h8000_0000_0000_0000, '1));
        pending_words.push_back(make_word(msie_pkg::FnMflo, '0, '0));
        pending_words.push_back(make_word(msie_pkg::FnMfhi, '0, '0));
        pending_words.push_back(make_word(msie_pkg::FnDiv, 64'h8000_0000, 64'hFFFF_FFFF));
        pending_words.push_back(make_word(msie_pkg::FnMflo, '0, '0));
        pending_words.push_back(make_word(msie_pkg::FnDivu, 64'd77,
                                          64'h1_0000_0000));      // by zero
        pending_words.push_back(make_word(msie_pkg::FnMfhi, '0, '0));
        pending_words.push_back(make_word(msie_pkg::FnDdivu, 64'd5, '0));   // by zero
        pending_words.push_back(make_word(msie_pkg::FnDmult, '1,
                                          64'h8000_0000_0000_0000));
        pending_words.push_back(make_word(msie_pkg::FnMfhi, '0, '0));
        pending_words.push_back(make_word(msie_pkg::FnDmultu, '1, '1));
        pending_words.push_back(make_word(msie_pkg::FnMflo, '0, '0));
        pending_words.push_back(make_word(msie_pkg::FnJalr, '1, '0));
        pending_words[$].pc = 32'hFFFF_FFFC;                                // link wraps
        pending_words.push_back(make_word(msie_pkg::FnJr, 64'h1234_5678_9ABC_DEF0, '0));
        pending_words.push_back(make_word(msie_pkg::FnDsra32, '0,
                                          64'h8000_0000_0000_0000));
        pending_words[$].shift_amount = 5'd31;
        pending_words.push_back(make_word(msie_pkg::FnDsrav, 64'h3F, '1));
        pending_words.push_back(make_word(msie_pkg::FnAdd, 64'h7FFF_FFFF, 64'd1));
        pending_words.push_back(make_word(msie_pkg::FnSlt, 64'h8000_0000_0000_0000, '0));
        pending_words.push_back(make_word(msie_pkg::FnMthi, '1, '0));
        pending_words.push_back(make_word(msie_pkg::FnMfhi, '0, '0));
        wait_drained();

        // receiver holds off while the sender keeps offering
        long_stall = 1'b1;
        for (i = 0; i < 20; i++)
            pending_words.push_back(make_word(pick_funct(), rand64(), rand64()));
        while (long_count < 400) @(posedge aclk);
        long_stall = 1'b0;
        wait_drained();

        for (i = 0; i < 1280; i++) begin
            fn = pick_funct();
            pending_words.push_back(make_word(fn, rand64(), rand64()));
            if (i == 640) begin
                wait_drained();
                sender_hold = 1'b1;       // sender pauses after all results came
                repeat (100) @(posedge aclk);
                sender_hold = 1'b0;
            end
        end
        wait_drained();
        stim_done = 1'b1;
        repeat (100) @(posedge aclk);
        if (mismatches == 0 && expected_results.size() == 0) begin
            $display("** mips64_special_integer_execute: PASSED **");
        end else begin
            $display("** mips64_special_integer_execute: FAILED **");
        end
        $finish;
    end
endmodule
`default_nettype wire
